// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is also checked while reset is high.
`define CHK_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== sv/clnsq_pkg.sv =====
// ----------------------------------------------------------------------------
// clnsq_pkg
// Types and constants shared by the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clnsq_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] CMD_INSTR = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_POS   = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_SHORT_WAIT = 1'b0;
   localparam logic CSR_LONG_WAIT  = 1'b1;

   localparam logic [15:0] SHORT_WAIT_RESET = 16'd40;
   localparam logic [15:0] LONG_WAIT_RESET  = 16'd2000;

   // Instruction codes of interest.
   localparam logic [7:0] INSTR_CLEAR   = 8'h01;
   localparam logic [7:0] INSTR_HOME    = 8'h02;
   localparam logic [3:0] FUNC_SET_HI   = 4'h2;
   localparam logic [7:0] SET_DDRAM     = 8'h80;
   localparam logic [6:0] DDRAM_MASK    = 7'h7F;
   localparam logic [6:0] ROW_STRIDE    = 7'h40;

   localparam int unsigned QUEUE_DEPTH = 2;

   // One classified request as handed from front to back.
   typedef struct packed {
      logic       rs;      // register select level
      logic [7:0] byte_v;  // byte to send
      logic       slow;    // clear or home: long wait
      logic       dup;     // 4-bit function set: repeat high nibble
   } desc_type;

   typedef struct packed {
      logic [15:0] short_wait;
      logic [15:0] long_wait;
   } waits_type;

endpackage

// ===== sv/char_lcd_nibble_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Turns LCD requests into nibble transfers for a 4-bit character display bus.
// ----------------------------------------------------------------------------
// A request is queued, then loaded into the back-end descriptor register, and
// its first nibble is driven on rsp from the registered output stage. The back
// end issues one nibble per cycle while rsp_tready is high: two nibbles per data
// request and two or three per instruction.
// Reset is synchronous: it empties the queue, idles the sequencer, drops
// rsp_tvalid and restores the wait registers to 40 us and 2000 us.
module char_lcd_nibble_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[7:0], row[8], col[14:9], zero[15]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // Response channel, one transaction per nibble transfer.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // nibble[3:0], wait_us[19:4], zero[23:20]
   output logic        rsp_tuser,   // reg_select
   output logic        rsp_tlast,   // last
   // Configuration write port.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import clnsq_pkg::*;

   waits_type  waits_ff, waits_in;
   desc_type   front_desc;
   desc_type   q_desc;
   logic       front_keep;
   logic       q_full;
   logic       q_not_empty;
   logic       q_push;
   logic       q_pop;
   logic [3:0] rsp_nibble;
   logic [15:0] rsp_wait;

   // The wait registers. Writes must arrive only while the block is idle (the block
   // does not enforce this), since the back end reads them live while it sequences.
   always_comb begin
      waits_in = waits_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHORT_WAIT: waits_in.short_wait = csr_wdata;
            CSR_LONG_WAIT:  waits_in.long_wait  = csr_wdata;
            default:        waits_in = waits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waits_ff.short_wait <= SHORT_WAIT_RESET;
         waits_ff.long_wait  <= LONG_WAIT_RESET;
      end else begin
         waits_ff <= waits_in;
      end
   end

   // Front end: the request is classified as it arrives. A request of an
   // unknown kind is still taken, but nothing is queued for it.
   clnsq_front u_front (
      .cmd   (req_tuser),
      .value (req_tdata[7:0]),
      .row   (req_tdata[8]),
      .col   (req_tdata[14:9]),
      .keep  (front_keep),
      .desc  (front_desc)
   );

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready && front_keep;

   // The queue decouples request intake from the nibble sequencer, so new
   // requests are taken while earlier ones are still being played out.
   clnsq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (front_desc),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_desc  (q_desc)
   );

   // Back end: one nibble per cycle, while the output is not stalled, into a registered output stage.
   clnsq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .waits       (waits_ff),
      .q_not_empty (q_not_empty),
      .q_desc      (q_desc),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_rs      (rsp_tuser),
      .out_nibble  (rsp_nibble),
      .out_wait    (rsp_wait),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, rsp_wait, rsp_nibble};

endmodule

// ===== sv/clnsq_front.sv =====
// ----------------------------------------------------------------------------
// clnsq_front
// Classifies an incoming request into a byte descriptor for the back end.
// ----------------------------------------------------------------------------
module clnsq_front (
   input  logic [1:0]          cmd,
   input  logic [7:0]          value,
   input  logic                row,
   input  logic [5:0]          col,
   output logic                keep,
   output clnsq_pkg::desc_type desc
);
   import clnsq_pkg::*;

   logic [6:0] addr;
   logic [7:0] byte_sel;

   assign addr = ({row, 6'd0} + {1'b0, col}) & DDRAM_MASK;

   always_comb begin
      keep     = 1'b1;
      desc.rs  = 1'b0;
      byte_sel = value;
      case (cmd)
         CMD_INSTR: begin
            desc.rs  = 1'b0;
            byte_sel = value;
         end
         CMD_DATA: begin
            desc.rs  = 1'b1;
            byte_sel = value;
         end
         CMD_POS: begin
            desc.rs  = 1'b0;
            byte_sel = SET_DDRAM + {1'b0, addr};
         end
         default: begin
            // Unknown kind: consumed and dropped.
            keep = 1'b0;
         end
      endcase
      desc.byte_v = byte_sel;
      desc.slow   = !desc.rs && ((byte_sel == INSTR_CLEAR) || (byte_sel == INSTR_HOME));
      desc.dup    = !desc.rs && (byte_sel[7:4] == FUNC_SET_HI);
   end

endmodule

// ===== sv/clnsq_queue.sv =====
// ----------------------------------------------------------------------------
// clnsq_queue
// Two-entry descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module clnsq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  clnsq_pkg::desc_type push_desc,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output clnsq_pkg::desc_type pop_desc
);
   import clnsq_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_desc  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== sv/clnsq_back.sv =====
// ----------------------------------------------------------------------------
// clnsq_back
// Nibble sequencer: plays one descriptor out as two or three transfers.
// ----------------------------------------------------------------------------
module clnsq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  clnsq_pkg::waits_type waits,
   input  logic                 q_not_empty,
   input  clnsq_pkg::desc_type  q_desc,
   output logic                 q_pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 out_rs,
   output logic [3:0]           out_nibble,
   output logic [15:0]          out_wait,
   output logic                 out_last
);
   import clnsq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_HIGH   = 4'b0010,
      ST_REPEAT = 4'b0100,
      ST_LOW    = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   desc_type    desc_ff, desc_in;
   logic        valid_ff, valid_in;
   logic        rs_ff, rs_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [15:0] wait_ff, wait_in;
   logic        last_ff, last_in;
   logic        emit;
   logic [15:0] byte_wait;

   assign emit      = (state_ff != ST_IDLE) && (!valid_ff || out_ready);
   assign byte_wait = desc_ff.slow ? waits.long_wait : waits.short_wait;

   always_comb begin
      state_in  = state_ff;
      desc_in   = desc_ff;
      rs_in     = rs_ff;
      nibble_in = nibble_ff;
      wait_in   = wait_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      valid_in  = emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               desc_in  = q_desc;
               state_in = ST_HIGH;
            end
         end
         ST_HIGH: begin
            if (emit) begin
               rs_in     = desc_ff.rs;
               nibble_in = desc_ff.byte_v[7:4];
               wait_in   = byte_wait;
               last_in   = 1'b0;
               state_in  = desc_ff.dup ? ST_REPEAT : ST_LOW;
            end
         end
         ST_REPEAT: begin
            if (emit) begin
               rs_in     = desc_ff.rs;
               nibble_in = desc_ff.byte_v[7:4];
               wait_in   = waits.short_wait;
               last_in   = 1'b0;
               state_in  = ST_LOW;
            end
         end
         ST_LOW: begin
            if (emit) begin
               rs_in     = desc_ff.rs;
               nibble_in = desc_ff.byte_v[3:0];
               wait_in   = byte_wait;
               last_in   = 1'b1;
               // Pick up the next descriptor straight from ST_LOW, without passing through ST_IDLE.
               if (q_not_empty) begin
                  q_pop    = 1'b1;
                  desc_in  = q_desc;
                  state_in = ST_HIGH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff   <= desc_in;
      rs_ff     <= rs_in;
      nibble_ff <= nibble_in;
      wait_ff   <= wait_in;
      last_ff   <= last_in;
   end

   assign out_valid  = valid_ff;
   assign out_rs     = rs_ff;
   assign out_nibble = nibble_ff;
   assign out_wait   = wait_ff;
   assign out_last   = last_ff;

endmodule

// ===== sv/clnsq_checker.sv =====
// ----------------------------------------------------------------------------
// clnsq_checker
// Port-level checks on the sequencer core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clnsq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   logic        rsp_stall;
   logic        rsp_mid;
   logic [25:0] rsp_payload;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_mid     = rsp_tvalid && rsp_tready && !rsp_tlast;
   assign rsp_payload = {rsp_tlast, rsp_tuser, rsp_tdata};

   // A stalled response stays offered.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid)

   // A stalled response keeps its payload.
   `CHK_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_payload))

   // Reset drops any pending response.
   `CHK_ASSERT_RST(a_rsp_reset, clock, reset |=> !rsp_tvalid)

   // Within one request the next nibble follows without a gap.
   `CHK_ASSERT(a_rsp_no_gap, clock, reset, rsp_mid |=> rsp_tvalid)

   // All nibbles of one request carry the same register select level.
   `CHK_ASSERT(a_rsp_same_rs, clock, reset, rsp_mid |=> (rsp_tuser == $past(rsp_tuser)))

endmodule

bind char_lcd_nibble_sequencer_core clnsq_checker u_clnsq_checker (.*);
